// ----- sv/kst_pkg.sv -----
package kst_pkg;

  localparam int MAX_EDGES_DEF    = 1024;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int LABEL_W  = 8;
  localparam int WEIGHT_W = WEIGHT_BITS_DEF;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 11;
  localparam int SUM_W    = 24;
  localparam int COMP_W   = 9;
  localparam int VCNT_W   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_VERT  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LABEL_W-1:0]  left_vertex;
    logic [LABEL_W-1:0]  right_vertex;
    logic [WEIGHT_W-1:0] link_weight;
    logic [INDEX_W-1:0]  edge_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  edge_total;
    logic [SUM_W-1:0]    tree_weight;
    logic                cycle_found;
    logic [COMP_W-1:0]   component_total;
    logic                is_primary;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_OUT,
    S_RD_WAIT,
    S_MCLR,
    S_PINIT,
    S_SEL_SCAN,
    S_SEL_RD,
    S_SEL_CMP,
    S_SEL_DONE,
    S_EDGE_WAIT,
    S_FA_RD,
    S_FA_WAIT,
    S_FB_RD,
    S_FB_WAIT,
    S_JOIN
  } state_t;

endpackage

// ----- sv/kst_if.sv -----
interface kst_in_if import kst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kst_out_if import kst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kst_cfg_if import kst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/kruskal_spanning_tree_engine.sv -----
// Kruskal spanning-tree engine. Load and read commands pass from accept
// through one edge/mark memory access (S_RD_WAIT) to the result register
// (S_OUT); rejected commands go straight to the result register. Clear
// wipes the mark memory one entry a cycle. A run selects edges by repeated
// scans of the edge store instead of sorting: each pick reads all loaded
// edges once through the single read port to find the smallest (weight,
// index) above the last pick. A run first wipes the mark memory and resets
// the parent memory; each pick then walks union-find parent reads up to the
// roots (root read included) and joins them if they differ. After reset a
// clearing pass runs over the mark memory before the first item is taken;
// configuration writes are accepted at any time.
module kruskal_spanning_tree_engine import kst_pkg::*; #(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  kst_in_if.sink  in_ch,
  kst_out_if.source out_ch,
  kst_cfg_if.sink cfg_ch
);
  localparam int EA_W = $clog2(MAX_EDGES);
  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int VC_W = $clog2(MAX_VERTICES + 1);
  localparam int ED_W = 2 * LABEL_W + WEIGHT_W;
  localparam int KEY_W = WEIGHT_W + EA_W;

  state_t state_r, state_nxt;

  logic [VCNT_W-1:0] vcnt_r;
  logic [EC_W-1:0]   loaded_r, loaded_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              cyc_r, cyc_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  in_item_t          item_r, item_nxt;
  out_item_t         res_r, res_nxt;

  // run working registers
  logic [EC_W-1:0]   cnt_r, cnt_nxt;     // picks done / sweep counter
  logic [EC_W-1:0]   scan_r, scan_nxt;
  logic              have_last_r, have_last_nxt;
  logic [KEY_W-1:0]  last_r, last_nxt;
  logic              have_best_r, have_best_nxt;
  logic [KEY_W-1:0]  best_r, best_nxt;
  logic [LABEL_W-1:0] eb_r, eb_nxt;
  logic [WEIGHT_W-1:0] ew_r, ew_nxt;
  logic [VA_W-1:0]   x_r, x_nxt, ra_r, ra_nxt;
  logic [VC_W-1:0]   vptr_r, vptr_nxt;
  logic [VC_W-1:0]   nv;

  // memories
  logic              e_we, m_we, p_we;
  logic [EA_W-1:0]   e_raddr, m_waddr, m_raddr;
  logic [ED_W-1:0]   e_rdata;
  logic              m_wdata, m_rdata;
  logic [VA_W-1:0]   p_waddr, p_raddr, p_wdata, p_rdata;

  kst_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(loaded_r[EA_W-1:0]),
    .wdata({item_r.left_vertex, item_r.right_vertex, item_r.link_weight}),
    .raddr(e_raddr), .rdata(e_rdata));
  kst_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_marks (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata));
  kst_ram #(.WIDTH(VA_W), .DEPTH(MAX_VERTICES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  always_comb begin
    if (vcnt_r == '0) nv = VC_W'(1);
    else if (32'(vcnt_r) > MAX_VERTICES) nv = VC_W'(MAX_VERTICES);
    else nv = VC_W'(vcnt_r);
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= VCNT_W'(256);
    end else if (cfg_ch.valid) begin
      vcnt_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      loaded_r <= '0;
      sum_r <= '0;
      cyc_r <= 1'b0;
      comp_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      loaded_r <= loaded_nxt;
      sum_r <= sum_nxt;
      cyc_r <= cyc_nxt;
      comp_r <= comp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r <= res_nxt;
    scan_r <= scan_nxt;
    have_last_r <= have_last_nxt;
    last_r <= last_nxt;
    have_best_r <= have_best_nxt;
    best_r <= best_nxt;
    eb_r <= eb_nxt;
    ew_r <= ew_nxt;
    x_r <= x_nxt;
    ra_r <= ra_nxt;
    vptr_r <= vptr_nxt;
  end

  logic [KEY_W-1:0] cur_key;
  logic [SUM_W:0]   sum_add;
  logic [LABEL_W-1:0] cur_l, cur_r;
  assign cur_l = e_rdata[ED_W-1 -: LABEL_W];
  assign cur_r = e_rdata[WEIGHT_W +: LABEL_W];
  assign cur_key = {e_rdata[WEIGHT_W-1:0], scan_r[EA_W-1:0]};
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(ew_r);

  always_comb begin
    state_nxt = state_r;
    loaded_nxt = loaded_r;
    sum_nxt = sum_r;
    cyc_nxt = cyc_r;
    comp_nxt = comp_r;
    cnt_nxt = cnt_r;
    item_nxt = item_r;
    res_nxt = res_r;
    scan_nxt = scan_r;
    have_last_nxt = have_last_r;
    last_nxt = last_r;
    have_best_nxt = have_best_r;
    best_nxt = best_r;
    eb_nxt = eb_r;
    ew_nxt = ew_r;
    x_nxt = x_r;
    ra_nxt = ra_r;
    vptr_nxt = vptr_r;
    e_we = 1'b0;
    e_raddr = scan_r[EA_W-1:0];
    m_we = 1'b0;
    m_waddr = cnt_r[EA_W-1:0];
    m_wdata = 1'b0;
    m_raddr = item_r.edge_index[EA_W-1:0];
    p_we = 1'b0;
    p_waddr = vptr_r[VA_W-1:0];
    p_wdata = vptr_r[VA_W-1:0];
    p_raddr = x_r;

    case (state_r)
      S_CLR: begin
        m_we = 1'b1;
        cnt_nxt = cnt_r + EC_W'(1);
        if (32'(cnt_r) == MAX_EDGES - 1) begin
          cnt_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // mark read for a read command starts here, data ready in S_RD_WAIT
        m_raddr = in_ch.data.edge_index[EA_W-1:0];
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          res_nxt.status = ST_OK;
          res_nxt.is_primary = 1'b0;
          case (cmd_t'(in_ch.data.cmd))
            CMD_LOAD: begin
              if (32'(loaded_r) >= MAX_EDGES) begin
                res_nxt.status = ST_FULL;
                state_nxt = S_OUT;
              end else if (VC_W'(in_ch.data.left_vertex) >= nv ||
                           VC_W'(in_ch.data.right_vertex) >= nv ||
                           32'(in_ch.data.left_vertex) >= MAX_VERTICES ||
                           32'(in_ch.data.right_vertex) >= MAX_VERTICES) begin
                res_nxt.status = ST_BAD_VERT;
                state_nxt = S_OUT;
              end else begin
                // write edge next cycle from item_r; mark of new slot is
                // already zero since marks are wiped on clear and run
                state_nxt = S_RD_WAIT;
              end
            end
            CMD_RUN: begin
              cnt_nxt = '0;
              state_nxt = S_MCLR;
            end
            CMD_READ: begin
              if (32'(in_ch.data.edge_index) >= 32'(loaded_r) ||
                  32'(in_ch.data.edge_index) >= MAX_EDGES) begin
                res_nxt.status = ST_BAD_INDEX;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              loaded_nxt = '0;
              sum_nxt = '0;
              cyc_nxt = 1'b0;
              comp_nxt = '0;
              cnt_nxt = '0;
              state_nxt = S_MCLR;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        if (cmd_t'(item_r.cmd) == CMD_LOAD) begin
          e_we = 1'b1;
          loaded_nxt = loaded_r + EC_W'(1);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      S_MCLR: begin
        m_we = 1'b1;
        cnt_nxt = cnt_r + EC_W'(1);
        if (32'(cnt_r) == MAX_EDGES - 1) begin
          cnt_nxt = '0;
          if (cmd_t'(item_r.cmd) == CMD_RUN) begin
            vptr_nxt = '0;
            state_nxt = S_PINIT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_PINIT: begin
        p_we = 1'b1;
        vptr_nxt = vptr_r + VC_W'(1);
        if (32'(vptr_r) == MAX_VERTICES - 1) begin
          sum_nxt = '0;
          cyc_nxt = 1'b0;
          comp_nxt = COMP_W'(nv);
          have_last_nxt = 1'b0;
          state_nxt = S_SEL_SCAN;
        end
      end
      S_SEL_SCAN: begin
        if (cnt_r == loaded_r) begin
          state_nxt = S_OUT;
        end else begin
          scan_nxt = '0;
          have_best_nxt = 1'b0;
          state_nxt = S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        // address scan_r presented; data valid next cycle
        state_nxt = S_SEL_CMP;
      end
      S_SEL_CMP: begin
        if ((!have_last_r || cur_key > last_r) &&
            (!have_best_r || cur_key < best_r)) begin
          have_best_nxt = 1'b1;
          best_nxt = cur_key;
        end
        scan_nxt = scan_r + EC_W'(1);
        if (scan_nxt == loaded_r) state_nxt = S_SEL_DONE;
        else state_nxt = S_SEL_RD;
      end
      S_SEL_DONE: begin
        last_nxt = best_r;
        have_last_nxt = 1'b1;
        cnt_nxt = cnt_r + EC_W'(1);
        e_raddr = best_r[EA_W-1:0];
        state_nxt = S_EDGE_WAIT;
      end
      S_EDGE_WAIT: begin
        eb_nxt = cur_r;
        ew_nxt = e_rdata[WEIGHT_W-1:0];
        // edge with a label beyond the current vertex count is skipped
        if (VC_W'(cur_l) >= nv || VC_W'(cur_r) >= nv) begin
          state_nxt = S_SEL_SCAN;
        end else begin
          x_nxt = VA_W'(cur_l);
          state_nxt = S_FA_RD;
        end
      end
      S_FA_RD: state_nxt = S_FA_WAIT;
      S_FA_WAIT: begin
        // p_rdata = parent[x]
        if (p_rdata == x_r) begin
          ra_nxt = x_r;
          x_nxt = VA_W'(eb_r);
          state_nxt = S_FB_RD;
        end else begin
          x_nxt = p_rdata;
          state_nxt = S_FA_RD;
        end
      end
      S_FB_RD: state_nxt = S_FB_WAIT;
      S_FB_WAIT: begin
        if (p_rdata == x_r) begin
          if (x_r == ra_r) begin
            cyc_nxt = 1'b1;
            state_nxt = S_SEL_SCAN;
          end else begin
            state_nxt = S_JOIN;
          end
        end else begin
          x_nxt = p_rdata;
          state_nxt = S_FB_RD;
        end
      end
      S_JOIN: begin
        p_we = 1'b1;
        p_waddr = ra_r;
        p_wdata = x_r;
        m_we = 1'b1;
        m_waddr = last_r[EA_W-1:0];
        m_wdata = 1'b1;
        comp_nxt = comp_r - COMP_W'(1);
        sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        state_nxt = S_SEL_SCAN;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_nxt == S_OUT) begin
      res_nxt.edge_total = TOTAL_W'(loaded_nxt);
      res_nxt.tree_weight = sum_nxt;
      res_nxt.cycle_found = cyc_nxt;
      res_nxt.component_total = comp_nxt;
      if (state_r == S_RD_WAIT && cmd_t'(item_r.cmd) == CMD_READ) begin
        res_nxt.is_primary = m_rdata;
      end
    end
  end
endmodule

// ----- sv/kst_ram.sv -----
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
